@@ rtl/core/tlbpt_pkg.sv @@
// Shared types and constants for the TLB and page table translator.
// No dependencies; imported by the page table and the top level.
package tlbpt_pkg;

   localparam int ADDR_WIDTH      = 16;
   localparam int FRAME_OUT_WIDTH = 8;
   localparam int COUNT_WIDTH     = 32;
   localparam int RSP_DATA_WIDTH  = 120;
   localparam int RSP_USER_WIDTH  = 2;

   // Bit positions of the flags in the result tuser.
   localparam int USER_TLB_HIT    = 0;
   localparam int USER_PAGE_FAULT = 1;

   // Requests from the sequencer to the page table memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tlbpt_ctrl_type;

endpackage

@@ rtl/core/tlbpt_cell.sv @@
// One TLB entry of the translator's cell chain.
// Standalone; instantiated as a row by tlb_page_table_translator.
module tlbpt_cell #(
   parameter int PAGE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic                 prev_valid,
   input  logic [PAGE_BITS-1:0] prev_tag,
   input  logic [PAGE_BITS-1:0] prev_frame,
   output logic                 ent_valid,
   output logic [PAGE_BITS-1:0] ent_tag,
   output logic [PAGE_BITS-1:0] ent_frame,
   input  logic [PAGE_BITS-1:0] look_page,
   input  logic                 found_in,
   input  logic [PAGE_BITS-1:0] hit_frame_in,
   output logic                 found_out,
   output logic [PAGE_BITS-1:0] hit_frame_out,
   output logic                 match
);

   logic                 valid_ff;
   logic [PAGE_BITS-1:0] tag_ff;
   logic [PAGE_BITS-1:0] frame_ff;

   // On a fill every entry takes its upstream neighbor's contents.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         tag_ff   <= prev_tag;
         frame_ff <= prev_frame;
      end
   end

   // Valid tags are unique, so the matching frame can simply be ORed down the row.
   assign match         = valid_ff && (tag_ff == look_page);
   assign found_out     = found_in | match;
   assign hit_frame_out = hit_frame_in | (match ? frame_ff : '0);

   assign ent_valid = valid_ff;
   assign ent_tag   = tag_ff;
   assign ent_frame = frame_ff;

endmodule

@@ rtl/core/tlbpt_page_table.sv @@
// Page table memory with a valid bit per page and a clearing pass after reset.
// Depends on tlbpt_pkg for the control struct.
module tlbpt_page_table #(
   parameter int PAGE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tlbpt_pkg::tlbpt_ctrl_type ctrl,
   input  logic [PAGE_BITS-1:0]    rd_page,
   input  logic [PAGE_BITS-1:0]    wr_page,
   input  logic [PAGE_BITS-1:0]    wr_frame,
   output logic                    rd_valid,
   output logic [PAGE_BITS-1:0]    rd_frame,
   output logic                    clear_busy
);
   import tlbpt_pkg::*;

   localparam int PAGE_COUNT = 1 << PAGE_BITS;

   // Each word holds the valid bit on top of the frame number.
   logic [PAGE_BITS:0]   mem [PAGE_COUNT];
   logic [PAGE_BITS:0]   rd_ff;
   logic [PAGE_BITS-1:0] clr_ff;
   logic                 clearing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == {PAGE_BITS{1'b1}}) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= '0;
      end else if (ctrl.wr_en) begin
         mem[wr_page] <= {1'b1, wr_frame};
      end
      if (ctrl.rd_en) begin
         rd_ff <= mem[rd_page];
      end
   end

   assign rd_valid   = rd_ff[PAGE_BITS];
   assign rd_frame   = rd_ff[PAGE_BITS-1:0];
   assign clear_busy = clearing_ff;

endmodule

@@ rtl/core/tlb_page_table_translator.sv @@
// Top level of the TLB and demand-paged page table translator.
// Depends on tlbpt_pkg, tlbpt_cell and tlbpt_page_table.

// This block translates one 16-bit logical address word at a time into a physical
// address. The page number is looked up in a row of TLB_ENTRIES cells that compare
// in parallel; on a miss the page table memory answers, and an unmapped page takes
// the next free frame and counts as a page fault. Every miss pushes the new pair
// into the head of the cell row and the oldest entry falls off the far end, which
// gives first-in first-out replacement. The accept cycle runs the TLB compare and
// issues the page table read; the lookup state then resolves the frame, writes back
// any new mapping and loads the result register. A new word is accepted only once
// the last one has loaded the result register; a held result stalls the lookup
// state. After reset the page table is cleared, one page per cycle, through all
// 2**PAGE_BITS pages (256 at the default) before the first word is accepted. The
// hit, fault and access totals wrap at 32 bits.
module tlb_page_table_translator #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_BITS   = 8,
   parameter int OFFSET_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request word; tdata: logical_address [15:0].
   input  logic [tlbpt_pkg::ADDR_WIDTH-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Result word; tdata: physical_address [15:0], frame_number [23:16],
   // hit_total [55:24], fault_total [87:56], access_total [119:88].
   output logic [tlbpt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // Result flags; tuser: tlb_hit [0], page_fault [1].
   output logic [tlbpt_pkg::RSP_USER_WIDTH-1:0] rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import tlbpt_pkg::*;

   localparam logic [PAGE_BITS:0] FRAME_LIMIT = {1'b1, {PAGE_BITS{1'b0}}};

   typedef enum logic {ST_IDLE, ST_LOOKUP} state_type;

   state_type                  state_ff, state_in;
   logic [PAGE_BITS-1:0]       page_ff;
   logic [OFFSET_BITS-1:0]     offset_ff;
   logic                       hit_ff;
   logic [PAGE_BITS-1:0]       hit_frame_ff;
   logic [PAGE_BITS:0]         next_free_ff, next_free_in;
   logic [COUNT_WIDTH-1:0]     hit_count_ff, hit_count_in;
   logic [COUNT_WIDTH-1:0]     fault_count_ff, fault_count_in;
   logic [COUNT_WIDTH-1:0]     access_count_ff, access_count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_USER_WIDTH-1:0]  rsp_user_ff, rsp_user_in;

   logic [ADDR_WIDTH+PAGE_BITS-1:0]     addr_ext;
   logic [PAGE_BITS-1:0]                req_page;
   logic [OFFSET_BITS-1:0]              req_offset;
   logic                                accept;
   logic                                done;
   logic                                fault;
   logic [PAGE_BITS-1:0]                frame_sel;
   logic [PAGE_BITS+FRAME_OUT_WIDTH-1:0] frame_ext;
   logic [OFFSET_BITS+PAGE_BITS+ADDR_WIDTH-1:0] phys_ext;
   tlbpt_ctrl_type                      pt_ctrl;
   logic                                pt_valid;
   logic [PAGE_BITS-1:0]                pt_frame;
   logic                                clear_busy;

   // Cell row wiring: index 0 is the fill input, index i+1 the output of cell i.
   logic                 ent_valid [TLB_ENTRIES+1];
   logic [PAGE_BITS-1:0] ent_tag   [TLB_ENTRIES+1];
   logic [PAGE_BITS-1:0] ent_frame [TLB_ENTRIES+1];
   logic                 chain_found [TLB_ENTRIES+1];
   logic [PAGE_BITS-1:0] chain_frame [TLB_ENTRIES+1];
   logic [TLB_ENTRIES-1:0] match_vec;
   logic                 tlb_fill;

   // Address bits above the page field are dropped; a full-width offset leaves page 0.
   assign addr_ext   = {{PAGE_BITS{1'b0}}, req_tdata};
   assign req_page   = addr_ext[OFFSET_BITS +: PAGE_BITS];
   assign req_offset = req_tdata[OFFSET_BITS-1:0];

   assign req_tready = (state_ff == ST_IDLE) && !clear_busy;
   assign accept     = req_tvalid && req_tready;

   // The lookup state finishes only when the result register can take the word.
   assign done = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_tready);

   // A miss on an unmapped page allocates the next free frame.
   assign fault     = !hit_ff && !pt_valid;
   assign frame_sel = hit_ff ? hit_frame_ff : (pt_valid ? pt_frame : next_free_ff[PAGE_BITS-1:0]);
   assign tlb_fill  = done && !hit_ff;

   assign pt_ctrl.rd_en = accept;
   assign pt_ctrl.wr_en = done && fault;

   // The new pair enters at the head of the row.
   assign ent_valid[0]   = 1'b1;
   assign ent_tag[0]     = page_ff;
   assign ent_frame[0]   = frame_sel;
   assign chain_found[0] = 1'b0;
   assign chain_frame[0] = '0;

   for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
      tlbpt_cell #(
         .PAGE_BITS(PAGE_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .shift         (tlb_fill),
         .prev_valid    (ent_valid[i]),
         .prev_tag      (ent_tag[i]),
         .prev_frame    (ent_frame[i]),
         .ent_valid     (ent_valid[i+1]),
         .ent_tag       (ent_tag[i+1]),
         .ent_frame     (ent_frame[i+1]),
         .look_page     (req_page),
         .found_in      (chain_found[i]),
         .hit_frame_in  (chain_frame[i]),
         .found_out     (chain_found[i+1]),
         .hit_frame_out (chain_frame[i+1]),
         .match         (match_vec[i])
      );
   end

   tlbpt_page_table #(
      .PAGE_BITS(PAGE_BITS)
   ) u_page_table (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (pt_ctrl),
      .rd_page    (req_page),
      .wr_page    (page_ff),
      .wr_frame   (next_free_ff[PAGE_BITS-1:0]),
      .rd_valid   (pt_valid),
      .rd_frame   (pt_frame),
      .clear_busy (clear_busy)
   );

   // Result formatting: frame number and physical address are cut to their port widths.
   assign frame_ext = {{FRAME_OUT_WIDTH{1'b0}}, frame_sel};
   assign phys_ext  = {{ADDR_WIDTH{1'b0}}, frame_sel, offset_ff};

   always_comb begin
      state_in        = state_ff;
      next_free_in    = next_free_ff;
      hit_count_in    = hit_count_ff;
      fault_count_in  = fault_count_ff;
      access_count_in = access_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_user_in     = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (done) begin
               state_in        = ST_IDLE;
               access_count_in = access_count_ff + 1'b1;
               if (hit_ff) begin
                  hit_count_in = hit_count_ff + 1'b1;
               end
               if (fault) begin
                  fault_count_in = fault_count_ff + 1'b1;
                  if (next_free_ff != FRAME_LIMIT) begin
                     next_free_in = next_free_ff + 1'b1;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {access_count_in, fault_count_in, hit_count_in,
                               frame_ext[FRAME_OUT_WIDTH-1:0], phys_ext[ADDR_WIDTH-1:0]};
               rsp_user_in                  = '0;
               rsp_user_in[USER_TLB_HIT]    = hit_ff;
               rsp_user_in[USER_PAGE_FAULT] = fault;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         next_free_ff    <= '0;
         hit_count_ff    <= '0;
         fault_count_ff  <= '0;
         access_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         next_free_ff    <= next_free_in;
         hit_count_ff    <= hit_count_in;
         fault_count_ff  <= fault_count_in;
         access_count_ff <= access_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // The TLB answer and the request fields are captured in the accept cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff      <= req_page;
         offset_ff    <= req_offset;
         hit_ff       <= chain_found[TLB_ENTRIES];
         hit_frame_ff <= chain_frame[TLB_ENTRIES];
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTH
   // Fills happen only on a miss, so no two valid cells ever hold the same page.
   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one TLB cell matches the page");

   a_write_on_miss: assert property (@(posedge clock) disable iff (reset)
      pt_ctrl.wr_en |-> (state_ff == ST_LOOKUP) && !hit_ff && !clear_busy)
      else $error("page table written outside a missing lookup");

   a_access_step: assert property (@(posedge clock) disable iff (reset)
      done |=> access_count_ff == $past(access_count_ff) + 1'b1)
      else $error("access total did not advance by one");

   a_frame_alloc: assert property (@(posedge clock) disable iff (reset)
      (done && fault) |=> (next_free_ff == $past(next_free_ff) + 1'b1) ||
                          ($past(next_free_ff) == FRAME_LIMIT))
      else $error("free frame counter did not advance on a fault");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[USER_TLB_HIT] && rsp_user_ff[USER_PAGE_FAULT]))
      else $error("result flags both a TLB hit and a page fault");
`endif

endmodule
